FILE: hw/rtl/gfrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfrd_pkg
// Shared widths, constants and types of the gyro frame rate decoder.
// ----------------------------------------------------------------------------
package gfrd_pkg;

  localparam int unsigned RawW      = 14;
  localparam int unsigned RateW     = 18;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned NumLanes  = 3;

  // lane order in the lane array
  localparam int unsigned LaneRoll  = 0;
  localparam int unsigned LanePitch = 1;
  localparam int unsigned LaneYaw   = 2;

  // register word index (paddr[AddrW-1:2])
  localparam logic RegThreshold = 1'b0;

  localparam logic [RawW-1:0] ThresholdReset = 14'd5000;
  localparam logic [RawW-1:0] SlowDeadband   = 14'd10;
  localparam logic [RawW-1:0] FastDeadband   = 14'd2;

  // per-lane findings handed to the merge stage
  typedef struct packed {
    logic                    above;    // raw strictly above threshold
    logic                    nonzero;  // lane holds a nonzero calibration
    logic signed [RateW-1:0] rate;     // rate against the held calibration
  } lane_res_t;

  // calibration write controls sent back to every lane
  typedef struct packed {
    logic capture;
    logic clear;
  } lane_ctl_t;

  // frame level decode of the current input item
  typedef struct packed {
    logic cmd;
    logic ext;
    logic frame;
    logic roll_slow;
    logic pitch_slow;
    logic yaw_slow;
  } frame_info_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gfrd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfrd_in_if / gfrd_out_if
// Valid/ready channels for sensor reports and decoded rate results.
// ----------------------------------------------------------------------------
interface gfrd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;

  modport source (output valid, cmd, byte0, byte1, byte2, byte3, byte4, byte5,
                  input ready);
  modport sink   (input valid, cmd, byte0, byte1, byte2, byte3, byte4, byte5,
                  output ready);
endinterface

interface gfrd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  gyro_frame;
  logic                                  extension_present;
  logic                                  roll_slow;
  logic                                  pitch_slow;
  logic                                  yaw_slow;
  logic signed [gfrd_pkg::RateW-1:0]     roll_rate;
  logic signed [gfrd_pkg::RateW-1:0]     pitch_rate;
  logic signed [gfrd_pkg::RateW-1:0]     yaw_rate;
  logic                                  calibrated;

  modport source (output valid, gyro_frame, extension_present, roll_slow, pitch_slow,
                  yaw_slow, roll_rate, pitch_rate, yaw_rate, calibrated,
                  input ready);
  modport sink   (input valid, gyro_frame, extension_present, roll_slow, pitch_slow,
                  yaw_slow, roll_rate, pitch_rate, yaw_rate, calibrated,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gfrd_axis_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfrd_axis_lane
// One axis: holds its calibration, subtracts, scales and applies deadband.
// ----------------------------------------------------------------------------
module gfrd_axis_lane (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [gfrd_pkg::RawW-1:0]    raw_i,
  input  wire logic                         slow_i,
  input  wire logic [gfrd_pkg::RawW-1:0]    threshold_i,
  input  wire gfrd_pkg::lane_ctl_t          ctl_i,
  output gfrd_pkg::lane_res_t               res_o
);

  logic [gfrd_pkg::RawW-1:0]           cal_q, cal_d;
  logic signed [gfrd_pkg::RawW:0]      diff;
  logic [gfrd_pkg::RawW-1:0]           mag;
  logic signed [gfrd_pkg::RateW-1:0]   diff_ext;
  logic signed [gfrd_pkg::RateW-1:0]   fast_rate;

  always_comb begin
    cal_d = cal_q;
    if (ctl_i.clear) begin
      cal_d = '0;
    end else if (ctl_i.capture) begin
      cal_d = raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign diff      = $signed({1'b0, raw_i}) - $signed({1'b0, cal_q});
  assign mag       = diff[gfrd_pkg::RawW] ? gfrd_pkg::RawW'(-diff)
                                          : diff[gfrd_pkg::RawW-1:0];
  assign diff_ext  = {{(gfrd_pkg::RateW - gfrd_pkg::RawW - 1){diff[gfrd_pkg::RawW]}}, diff};
  // times five as shift and add
  assign fast_rate = (diff_ext <<< 2) + diff_ext;

  always_comb begin
    res_o.above   = raw_i > threshold_i;
    res_o.nonzero = |cal_q;
    if (slow_i) begin
      res_o.rate = (mag < gfrd_pkg::SlowDeadband) ? '0 : diff_ext;
    end else begin
      res_o.rate = (mag < gfrd_pkg::FastDeadband) ? '0 : fast_rate;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gfrd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfrd_merge
// Combines the lane findings, decides calibration capture/clear and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module gfrd_merge (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         in_valid_i,
  output logic                                              in_ready_o,
  input  wire gfrd_pkg::frame_info_t                        info_i,
  input  wire gfrd_pkg::lane_res_t [gfrd_pkg::NumLanes-1:0] lane_i,
  output gfrd_pkg::lane_ctl_t                               ctl_o,
  gfrd_out_if.source                                        out_o
);

  logic out_valid_q, out_valid_d;
  logic in_fire;
  logic all_above;
  logic held;
  logic capture_ok;
  logic calibrated_d;

  assign in_ready_o = !out_valid_q || out_o.ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    all_above = 1'b1;
    held      = 1'b0;
    for (int i = 0; i < gfrd_pkg::NumLanes; i++) begin
      all_above = all_above & lane_i[i].above;
      held      = held | lane_i[i].nonzero;
    end
  end

  // first capture only, and only on a decoded gyro frame
  assign capture_ok    = info_i.frame && all_above && !held;
  assign ctl_o.capture = in_fire && capture_ok;
  assign ctl_o.clear   = in_fire && info_i.cmd;

  assign calibrated_d = !info_i.cmd && (held || capture_ok);

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_o.gyro_frame        <= info_i.frame;
      out_o.extension_present <= info_i.ext && !info_i.cmd;
      out_o.roll_slow         <= info_i.frame && info_i.roll_slow;
      out_o.pitch_slow        <= info_i.frame && info_i.pitch_slow;
      out_o.yaw_slow          <= info_i.frame && info_i.yaw_slow;
      // a capturing frame measures zero against itself
      out_o.roll_rate  <= (info_i.frame && !capture_ok) ? lane_i[gfrd_pkg::LaneRoll].rate  : '0;
      out_o.pitch_rate <= (info_i.frame && !capture_ok) ? lane_i[gfrd_pkg::LanePitch].rate : '0;
      out_o.yaw_rate   <= (info_i.frame && !capture_ok) ? lane_i[gfrd_pkg::LaneYaw].rate   : '0;
      out_o.calibrated <= calibrated_d;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/gyro_frame_rate_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_frame_rate_decoder
// Three-axis gyro report decoder with calibration capture and deadband.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              carries
//  in_i      in    valid/ready            cmd, report bytes 0..5
//  out_o     out   valid/ready            flags, three rates, calibrated
//  apb       in    psel/penable/pwrite    calibration_threshold at 0x0
//
//  One report per cycle while the output is not stalled; a result appears in the cycle after its transfer.
//  The three axis lanes and the merge logic are one combinational step
//  ahead of the output register, which sets the latency.
//  Input is taken whenever the output register is empty or being drained.
//  Reset clears the calibration and loads the threshold with 5000.
// ----------------------------------------------------------------------------
module gyro_frame_rate_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  gfrd_in_if.sink                            in_i,
  gfrd_out_if.source                         out_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [gfrd_pkg::AddrW-1:0]    paddr_i,
  input  wire logic [gfrd_pkg::DataW-1:0]    pwdata_i,
  output logic [gfrd_pkg::DataW-1:0]         prdata_o,
  output logic                               pready_o
);

  logic [gfrd_pkg::RawW-1:0]                  threshold_q, threshold_d;
  logic                                       reg_sel;
  gfrd_pkg::frame_info_t                      info;
  gfrd_pkg::lane_res_t [gfrd_pkg::NumLanes-1:0] lane_res;
  gfrd_pkg::lane_ctl_t                        lane_ctl;
  logic [gfrd_pkg::RawW-1:0]                  raw   [gfrd_pkg::NumLanes];
  logic                                       slow  [gfrd_pkg::NumLanes];
  logic                                       in_ready;

  // configuration port
  assign pready_o = 1'b1;
  assign reg_sel  = paddr_i[gfrd_pkg::AddrW-1:2] == gfrd_pkg::RegThreshold;

  always_comb begin
    threshold_d = threshold_q;
    if (psel_i && penable_i && pwrite_i && reg_sel) begin
      threshold_d = pwdata_i[gfrd_pkg::RawW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= gfrd_pkg::ThresholdReset;
    end else begin
      threshold_q <= threshold_d;
    end
  end

  assign prdata_o = reg_sel ? {{(gfrd_pkg::DataW - gfrd_pkg::RawW){1'b0}}, threshold_q} : '0;

  // report unpacking
  always_comb begin
    info.cmd        = in_i.cmd;
    info.ext        = in_i.byte4[0];
    info.frame      = !in_i.cmd && (!in_i.byte4[0] || in_i.byte5[1]);
    info.roll_slow  = in_i.byte4[1];
    info.pitch_slow = in_i.byte3[0];
    info.yaw_slow   = in_i.byte3[1];
  end

  assign raw[gfrd_pkg::LaneRoll]   = {in_i.byte4[7:2], in_i.byte1};
  assign raw[gfrd_pkg::LanePitch]  = {in_i.byte5[7:2], in_i.byte2};
  assign raw[gfrd_pkg::LaneYaw]    = {in_i.byte3[7:2], in_i.byte0};
  assign slow[gfrd_pkg::LaneRoll]  = info.roll_slow;
  assign slow[gfrd_pkg::LanePitch] = info.pitch_slow;
  assign slow[gfrd_pkg::LaneYaw]   = info.yaw_slow;

  for (genvar g = 0; g < gfrd_pkg::NumLanes; g++) begin : g_lane
    gfrd_axis_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .raw_i       (raw[g]),
      .slow_i      (slow[g]),
      .threshold_i (threshold_q),
      .ctl_i       (lane_ctl),
      .res_o       (lane_res[g])
    );
  end

  gfrd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .info_i     (info),
    .lane_i     (lane_res),
    .ctl_o      (lane_ctl),
    .out_o      (out_o)
  );

  assign in_i.ready = in_ready;

endmodule
`default_nettype wire
